// ===== hw/rtl/skf_pkg.sv =====
// Package for the scalar Kalman filter: widths, reset values, register indexes,
// controller state and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package skf_pkg;

	localparam int unsigned MEAS_W = 16;
	localparam int unsigned COV_W  = 24;
	localparam int unsigned GAIN_W = 16;
	localparam int unsigned DEN_W  = COV_W + 1;
	localparam int unsigned REM_W  = COV_W + 2;
	localparam int unsigned CNT_W  = $clog2(GAIN_W);

	localparam logic [COV_W-1:0]  COV_MAX       = {COV_W{1'b1}};
	localparam logic [COV_W-1:0]  Q_ONE         = 24'h01_0000;
	localparam logic [GAIN_W-1:0] GAIN_MAX      = {GAIN_W{1'b1}};
	localparam logic [COV_W-1:0]  RST_PROC_NOISE = '0;
	localparam logic [COV_W-1:0]  RST_MEAS_NOISE = Q_ONE;
	localparam logic [MEAS_W-1:0] RST_ESTIMATE   = '0;
	localparam logic [COV_W-1:0]  RST_COVARIANCE = Q_ONE;

	typedef enum logic [1:0] {
		CFG_PROCESS_NOISE      = 2'd0,
		CFG_MEASUREMENT_NOISE  = 2'd1,
		CFG_INITIAL_ESTIMATE   = 2'd2,
		CFG_INITIAL_COVARIANCE = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_DINIT,
		ST_DIV,
		ST_MULX,
		ST_MULP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic pred;
		logic dinit;
		logic div_step;
		logic mul_x;
		logic mul_p;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_skip;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skf_in_if.sv =====
// Measurement channel: valid/ready handshake carrying one signed Q8.8 sample.
// Depends on skf_pkg.
`default_nettype none

interface skf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [skf_pkg::MEAS_W-1:0]   measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/skf_out_if.sv =====
// Result channel: valid/ready handshake carrying estimate, covariance and gain.
// Depends on skf_pkg.
`default_nettype none

interface skf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [skf_pkg::MEAS_W-1:0]   estimate;
	logic [skf_pkg::COV_W-1:0]           covariance;
	logic [skf_pkg::GAIN_W-1:0]          gain;

	modport source (output valid, output estimate, output covariance, output gain,
		input ready);
	modport sink (input valid, input estimate, input covariance, input gain,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/skf_ctrl.sv =====
// Controller of the scalar Kalman filter: sequences predict, serial divide,
// the two multiplies and write-back. Depends on skf_pkg.
`default_nettype none

module skf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire skf_pkg::status_t  status,
	output skf_pkg::cmd_t          cmd
);

	skf_pkg::state_t               state_q, state_d;
	logic [skf_pkg::CNT_W-1:0]     cnt_q;
	logic                          cnt_last;

	assign cnt_last = (cnt_q == skf_pkg::CNT_W'(skf_pkg::GAIN_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.dinit) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skf_pkg::ST_IDLE:  if (in_valid) state_d = skf_pkg::ST_PRED;
			skf_pkg::ST_PRED:  state_d = skf_pkg::ST_DINIT;
			skf_pkg::ST_DINIT: state_d = status.div_skip ? skf_pkg::ST_MULX : skf_pkg::ST_DIV;
			skf_pkg::ST_DIV:   if (cnt_last) state_d = skf_pkg::ST_MULX;
			skf_pkg::ST_MULX:  state_d = skf_pkg::ST_MULP;
			skf_pkg::ST_MULP:  state_d = skf_pkg::ST_FIN;
			skf_pkg::ST_FIN:   if (status.out_free) state_d = skf_pkg::ST_IDLE;
			default:           state_d = skf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			skf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			skf_pkg::ST_PRED:  cmd.pred     = 1'b1;
			skf_pkg::ST_DINIT: cmd.dinit    = 1'b1;
			skf_pkg::ST_DIV:   cmd.div_step = 1'b1;
			skf_pkg::ST_MULX:  cmd.mul_x    = 1'b1;
			skf_pkg::ST_MULP:  cmd.mul_p    = 1'b1;
			skf_pkg::ST_FIN:   cmd.finish   = status.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/skf_dp.sv =====
// Datapath of the scalar Kalman filter: configuration and filter state, the
// restoring gain divider, the two multipliers and the result register.
// Depends on skf_pkg.
`default_nettype none

module skf_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire skf_pkg::cfg_reg_t                 cfg_sel,
	input  wire logic [skf_pkg::COV_W-1:0]         cfg_data,
	input  wire skf_pkg::cmd_t                     cmd,
	output skf_pkg::status_t                       status,
	input  wire logic signed [skf_pkg::MEAS_W-1:0] in_measurement,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [skf_pkg::MEAS_W-1:0]      out_estimate,
	output logic [skf_pkg::COV_W-1:0]              out_covariance,
	output logic [skf_pkg::GAIN_W-1:0]             out_gain
);

	localparam int unsigned MW = skf_pkg::MEAS_W;
	localparam int unsigned CW = skf_pkg::COV_W;
	localparam int unsigned GW = skf_pkg::GAIN_W;
	localparam int unsigned PXW = 2 * (MW + 1);        // K * (z - x)
	localparam int unsigned FW  = PXW + 1;             // x * 2^16 + K * (z - x)
	localparam int unsigned PPW = (GW + 1) + CW;       // (1 - K) * Pp

	logic [CW-1:0]                 q_q, r_q, cov_q, pp_q, covn_q;
	logic signed [MW-1:0]          est_q, z_q;
	logic [skf_pkg::DEN_W-1:0]     den_q;
	logic [skf_pkg::REM_W-1:0]     rem_q;
	logic [GW-1:0]                 quo_q;
	logic signed [PXW-1:0]         prodx_q;
	logic                          out_valid_q;

	// predict
	logic [CW:0]                   pred_sum;
	logic [CW-1:0]                 pp_next;
	// divider step
	logic [skf_pkg::REM_W-1:0]     rem_sh, den_ext;
	logic                          rem_ge;
	// multipliers
	logic signed [MW:0]            k_s, diff;
	logic [GW:0]                   one_minus_k;
	logic [PPW-1:0]                prodp;
	// estimate rounding
	logic signed [FW-1:0]          full;
	logic signed [FW-GW-1:0]       qt;
	logic signed [MW-1:0]          est_next;

	assign pred_sum = {1'b0, cov_q} + {1'b0, q_q};
	assign pp_next  = pred_sum[CW] ? skf_pkg::COV_MAX : pred_sum[CW-1:0];

	assign rem_sh  = {rem_q[skf_pkg::REM_W-2:0], 1'b0};
	assign den_ext = {1'b0, den_q};
	assign rem_ge  = (rem_sh >= den_ext);

	assign k_s         = $signed({1'b0, quo_q});
	assign diff        = {z_q[MW-1], z_q} - {est_q[MW-1], est_q};
	assign one_minus_k = {1'b1, {GW{1'b0}}} - {1'b0, quo_q};
	assign prodp       = {{CW{1'b0}}, one_minus_k} * {{(GW+1){1'b0}}, pp_q};

	// Truncate toward zero: bump a negative quotient when bits were dropped.
	assign full = $signed({{(FW-MW-GW){est_q[MW-1]}}, est_q, {GW{1'b0}}})
		+ $signed({prodx_q[PXW-1], prodx_q});
	assign qt   = full[FW-1:GW] + $signed({{(FW-GW-1){1'b0}},
		(full[FW-1] && (|full[GW-1:0]))});

	always_comb begin
		if (qt[FW-GW-1:MW-1] == '0 || qt[FW-GW-1:MW-1] == '1) begin
			est_next = qt[MW-1:0];
		end else if (qt[FW-GW-1]) begin
			est_next = {1'b1, {(MW-1){1'b0}}};
		end else begin
			est_next = {1'b0, {(MW-1){1'b1}}};
		end
	end

	assign status.div_skip = (r_q == '0);
	assign status.out_free = !out_valid_q || out_ready;

	// Configuration and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q         <= skf_pkg::RST_PROC_NOISE;
			r_q         <= skf_pkg::RST_MEAS_NOISE;
			est_q       <= skf_pkg::RST_ESTIMATE;
			cov_q       <= skf_pkg::RST_COVARIANCE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_sel)
					skf_pkg::CFG_PROCESS_NOISE:      q_q   <= cfg_data;
					skf_pkg::CFG_MEASUREMENT_NOISE:  r_q   <= cfg_data;
					skf_pkg::CFG_INITIAL_ESTIMATE:   est_q <= cfg_data[MW-1:0];
					skf_pkg::CFG_INITIAL_COVARIANCE: cov_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.finish) begin
				est_q       <= est_next;
				cov_q       <= covn_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			z_q <= in_measurement;
		end
		if (cmd.pred) begin
			pp_q <= pp_next;
		end
		if (cmd.dinit) begin
			den_q <= {1'b0, pp_q} + {1'b0, r_q};
			rem_q <= {2'b00, pp_q};
			// no noise term: gain is one (clamped) or zero
			quo_q <= (pp_q == '0) ? '0 : skf_pkg::GAIN_MAX;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? (rem_sh - den_ext) : rem_sh;
			quo_q <= {quo_q[GW-2:0], rem_ge};
		end
		if (cmd.mul_x) begin
			prodx_q <= k_s * diff;
		end
		if (cmd.mul_p) begin
			covn_q <= prodp[PPW-2:GW];
		end
		if (cmd.finish) begin
			out_estimate   <= est_next;
			out_covariance <= covn_q;
			out_gain       <= quo_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/scalar_kalman_filter_top.sv =====
// Scalar Kalman filter top level. An accepted item passes through predict, divider
// setup, 16 restoring divide steps (skipped when the sensor noise register is zero),
// two multiplies and write-back before result valid rises; a new item is accepted
// only once the controller is back in idle; write-back stalls while the previous
// result waits. Reset (arst_n, async) loads Q=0, R=1.0, estimate 0 and covariance
// 1.0 and leaves the result channel empty.
`default_nettype none

module scalar_kalman_filter_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [skf_pkg::COV_W-1:0]  cfg_data,
	skf_in_if.sink                          sample,
	skf_out_if.source                       result
);

	skf_pkg::cmd_t     cmd;
	skf_pkg::status_t  status;
	logic              in_ready;

	// Controller: walks one item through predict, divide, multiply, write-back.
	// Takes items only in idle; the user must not let config writes race the datapath.
	skf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: the result register decouples the output side, so the next item
	// is taken while a finished result still waits for the sink.
	skf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_sel        (skf_pkg::cfg_reg_t'(cfg_index)),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.status         (status),
		.in_measurement (sample.measurement),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.out_estimate   (result.estimate),
		.out_covariance (result.covariance),
		.out_gain       (result.gain)
	);

	assign sample.ready = in_ready;

	// An accepted item keeps the input closed for the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("input reopened right after accept");

	// A fresh result only appears at the end of an item's processing.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!sample.ready))
		else $error("result raised without an item in flight");

	// Write-back is issued only when the result register can take it.
	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!result.valid || result.ready))
		else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
